// ===== design/cta2a_pkg.sv =====
package cta2a_pkg;

   localparam int RUN_MAX     = 7;
   localparam int LEN_W       = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] PREFIX_BYTE = 8'h01;
   localparam logic [7:0] ESC_BYTE    = 8'h1B;
   localparam logic [7:0] SUB_BYTE    = 8'h1A;
   localparam logic [7:0] CURSOR_BASE = 8'h7F;
   localparam logic [7:0] END_CODE    = 8'h5A;

   // one converted run: bytes[0] goes out first, len is 1 to RUN_MAX
   typedef struct packed {
      logic [RUN_MAX-1:0][7:0] bytes;
      logic [LEN_W-1:0]        len;
   } run_type;

endpackage

// ===== design/ctrl_a_to_ansi_converter.sv =====
// Converts a byte stream with 0x01-prefixed attribute codes into ANSI escape
// sequences. Each request is one input byte; it yields zero to seven response
// bytes, and rsp_run_end marks the last byte of each request's run. A request
// is accepted whenever the run queue (QUEUE_DEPTH entries) has room; the output
// side sends one byte per cycle while rsp_stall is low, and plain bytes stream at one
// per cycle while neither side stalls; prefix bytes, the end code and dropped bytes
// produce nothing. The first byte out is written into the run queue on acceptance
// and then registered in the output stage.
// csr_wr_data written with csr_wr_en sets strip_unknown (1 drops unknown codes).
module ctrl_a_to_ansi_converter #(
   parameter int QUEUE_DEPTH = cta2a_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import cta2a_pkg::*;

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_head_valid;
   run_type q_push_run;
   run_type q_head_run;

   cta2a_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_run       (q_push_run)
   );

   cta2a_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_run   (q_push_run),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_run   (q_head_run)
   );

   cta2a_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (q_head_valid),
      .head_run     (q_head_run),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_end  (rsp_run_end)
   );

endmodule

// ===== design/cta2a_front.sv =====
module cta2a_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_in_byte,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              q_full,
   output logic              q_push,
   output cta2a_pkg::run_type q_run
);
   import cta2a_pkg::*;

   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_A       = 8'h41;
   localparam logic [7:0] CH_B       = 8'h42;
   localparam logic [7:0] CH_C       = 8'h43;
   localparam logic [7:0] CH_G       = 8'h47;
   localparam logic [7:0] CH_H       = 8'h48;
   localparam logic [7:0] CH_I       = 8'h49;
   localparam logic [7:0] CH_J       = 8'h4A;
   localparam logic [7:0] CH_K       = 8'h4B;
   localparam logic [7:0] CH_L       = 8'h4C;
   localparam logic [7:0] CH_M       = 8'h4D;
   localparam logic [7:0] CH_N       = 8'h4E;
   localparam logic [7:0] CH_R       = 8'h52;
   localparam logic [7:0] CH_W       = 8'h57;
   localparam logic [7:0] CH_Y       = 8'h59;
   localparam logic [7:0] CH_LC_A    = 8'h61;
   localparam logic [7:0] CH_LC_Z    = 8'h7A;
   localparam logic [7:0] CH_LOWER_M = 8'h6D;
   localparam logic [7:0] CH_BS      = 8'h08;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   logic prefix_seen_ff, prefix_seen_in;
   logic stream_ended_ff, stream_ended_in;
   logic strip_unknown_ff, strip_unknown_in;

   logic        accept;
   logic [7:0]  b;
   logic [7:0]  u;
   logic [7:0]  cnt;
   logic [6:0]  rem;
   logic [14:0] prod;
   logic [3:0]  tens;
   logic [6:0]  ones_full;
   logic [7:0]  tens_ch;
   logic [7:0]  ones_ch;
   logic        push;
   run_type     run;

   function automatic run_type make_run(input logic [LEN_W-1:0] n,
                                        input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3,
                                        input logic [7:0] b4, input logic [7:0] b5,
                                        input logic [7:0] b6);
      run_type r;
      r.len      = n;
      r.bytes[0] = b0;
      r.bytes[1] = b1;
      r.bytes[2] = b2;
      r.bytes[3] = b3;
      r.bytes[4] = b4;
      r.bytes[5] = b5;
      r.bytes[6] = b6;
      return r;
   endfunction

   // ESC [ followed by a three-byte tail
   function automatic run_type csi3(input logic [7:0] t0, input logic [7:0] t1,
                                    input logic [7:0] t2);
      return make_run(LEN_W'(5), ESC_BYTE, CH_LBRACK, t0, t1, t2, 8'h00, 8'h00);
   endfunction

   function automatic run_type csi2(input logic [7:0] t0, input logic [7:0] t1);
      return make_run(LEN_W'(4), ESC_BYTE, CH_LBRACK, t0, t1, 8'h00, 8'h00, 8'h00);
   endfunction

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign b         = req_in_byte;
   assign u         = (b >= CH_LC_A && b <= CH_LC_Z) ? (b & ~CASE_BIT) : b;

   // split the cursor count (1..128) into decimal digits
   assign cnt       = b - CURSOR_BASE;
   assign rem       = (cnt >= 8'd100) ? 7'(cnt - 8'd100) : cnt[6:0];
   assign prod      = 15'(rem) * 15'd205;
   assign tens      = prod[14:11];
   assign ones_full = rem - 7'(7'(tens) * 7'd10);
   assign tens_ch   = ASCII_ZERO | {4'b0000, tens};
   assign ones_ch   = ASCII_ZERO | {4'b0000, ones_full[3:0]};

   always_comb begin
      push             = 1'b0;
      run              = make_run(LEN_W'(1), b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      prefix_seen_in   = prefix_seen_ff;
      stream_ended_in  = stream_ended_ff;
      strip_unknown_in = csr_wr_en ? csr_wr_data : strip_unknown_ff;
      if (accept && !stream_ended_ff) begin
         if (prefix_seen_ff) begin
            prefix_seen_in = 1'b0;
            if (b == END_CODE) begin
               stream_ended_in = 1'b1;
            end else if (b > CURSOR_BASE) begin
               push = 1'b1;
               if (cnt == 8'd1) begin
                  run = make_run(LEN_W'(3), ESC_BYTE, CH_LBRACK, CH_C,
                                 8'h00, 8'h00, 8'h00, 8'h00);
               end else if (cnt < 8'd10) begin
                  run = make_run(LEN_W'(4), ESC_BYTE, CH_LBRACK, ones_ch, CH_C,
                                 8'h00, 8'h00, 8'h00);
               end else if (cnt < 8'd100) begin
                  run = make_run(LEN_W'(5), ESC_BYTE, CH_LBRACK, tens_ch, ones_ch, CH_C,
                                 8'h00, 8'h00);
               end else begin
                  run = make_run(LEN_W'(6), ESC_BYTE, CH_LBRACK, ASCII_ZERO | 8'h01,
                                 tens_ch, ones_ch, CH_C, 8'h00);
               end
            end else begin
               push = 1'b1;
               unique case (u)
                  CH_A:      run = make_run(LEN_W'(1), PREFIX_BYTE, 8'h00, 8'h00, 8'h00,
                                            8'h00, 8'h00, 8'h00);
                  CH_LT:     run = make_run(LEN_W'(1), CH_BS, 8'h00, 8'h00, 8'h00,
                                            8'h00, 8'h00, 8'h00);
                  CH_GT:     run = make_run(LEN_W'(3), ESC_BYTE, CH_LBRACK, CH_K,
                                            8'h00, 8'h00, 8'h00, 8'h00);
                  CH_LBRACK: run = make_run(LEN_W'(1), CH_CR, 8'h00, 8'h00, 8'h00,
                                            8'h00, 8'h00, 8'h00);
                  CH_RBRACK: run = make_run(LEN_W'(1), CH_LF, 8'h00, 8'h00, 8'h00,
                                            8'h00, 8'h00, 8'h00);
                  CH_L:      run = make_run(LEN_W'(7), ESC_BYTE, CH_LBRACK, 8'h32, CH_J,
                                            ESC_BYTE, CH_LBRACK, CH_H);
                  CH_DASH, CH_UNDER, CH_N:
                             run = csi2(8'h30, CH_LOWER_M);
                  CH_H:      run = csi2(8'h31, CH_LOWER_M);
                  CH_I:      run = csi2(8'h35, CH_LOWER_M);
                  CH_K:      run = csi3(8'h33, 8'h30, CH_LOWER_M);
                  CH_R:      run = csi3(8'h33, 8'h31, CH_LOWER_M);
                  CH_G:      run = csi3(8'h33, 8'h32, CH_LOWER_M);
                  CH_Y:      run = csi3(8'h33, 8'h33, CH_LOWER_M);
                  CH_B:      run = csi3(8'h33, 8'h34, CH_LOWER_M);
                  CH_M:      run = csi3(8'h33, 8'h35, CH_LOWER_M);
                  CH_C:      run = csi3(8'h33, 8'h36, CH_LOWER_M);
                  CH_W:      run = csi3(8'h33, 8'h37, CH_LOWER_M);
                  8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37:
                             run = csi3(8'h34, u, CH_LOWER_M);
                  // only the lowercase end letter reaches here
                  END_CODE:  run = make_run(LEN_W'(1), SUB_BYTE, 8'h00, 8'h00, 8'h00,
                                            8'h00, 8'h00, 8'h00);
                  default: begin
                     push = !strip_unknown_ff;
                     run  = make_run(LEN_W'(2), PREFIX_BYTE, b, 8'h00, 8'h00,
                                     8'h00, 8'h00, 8'h00);
                  end
               endcase
            end
         end else if (b == PREFIX_BYTE) begin
            prefix_seen_in = 1'b1;
         end else begin
            push = 1'b1;
         end
      end
   end

   assign q_push = push;
   assign q_run  = run;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_seen_ff   <= 1'b0;
         stream_ended_ff  <= 1'b0;
         strip_unknown_ff <= 1'b0;
      end else begin
         prefix_seen_ff   <= prefix_seen_in;
         stream_ended_ff  <= stream_ended_in;
         strip_unknown_ff <= strip_unknown_in;
      end
   end

endmodule

// ===== design/cta2a_queue.sv =====
module cta2a_queue #(
   parameter int DEPTH = cta2a_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cta2a_pkg::run_type push_run,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output cta2a_pkg::run_type head_run
);
   import cta2a_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   run_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_run   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wrap_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/cta2a_back.sv =====
module cta2a_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  cta2a_pkg::run_type head_run,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_run_end
);
   import cta2a_pkg::*;

   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             end_ff, end_in;
   logic             load;
   logic             last;

   assign load = !valid_ff || !rsp_stall;
   assign last = (idx_ff == head_run.len - LEN_W'(1));
   assign pop  = load && head_valid && last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            byte_in = head_run.bytes[idx_ff];
            end_in  = last;
            // advance within the run, restart on the next one
            idx_in  = last ? '0 : idx_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_end  = end_ff;

endmodule

// ===== design/cta2a_checker.sv =====
module cta2a_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_end
);
   import cta2a_pkg::*;

   // queue is empty right after reset
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("busy right after reset");

   // a run never breaks off in the middle
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_end |=> rsp_valid)
      else $error("gap inside a run");

   // an escape that does not end its run opens a control sequence
   a_esc_then_bracket: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_end && rsp_out_byte == ESC_BYTE
      |=> rsp_out_byte == 8'h5B)
      else $error("escape not followed by bracket");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall
      |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_end))
      else $error("stalled response changed");

endmodule

bind ctrl_a_to_ansi_converter cta2a_checker u_cta2a_checker (.*);

// ===== tb/sv/ctrl_a_to_ansi_converter_tb.sv =====
module ctrl_a_to_ansi_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cta2a_pkg::*;

   // attribute code bytes, upper case where the code is a letter
   localparam logic [7:0] CODE_LITERAL_PREFIX = "A";
   localparam logic [7:0] CODE_BACKSPACE      = "<";
   localparam logic [7:0] CODE_ERASE_EOL      = ">";
   localparam logic [7:0] CODE_CR             = "[";
   localparam logic [7:0] CODE_LF             = "]";
   localparam logic [7:0] CODE_CLEAR_HOME     = "L";
   localparam logic [7:0] CODE_NORMAL         = "N";
   localparam logic [7:0] CODE_NORMAL_DASH    = "-";
   localparam logic [7:0] CODE_NORMAL_UNDER   = "_";
   localparam logic [7:0] CODE_BOLD           = "H";
   localparam logic [7:0] CODE_BLINK          = "I";
   localparam logic [7:0] CODE_FG_BLACK       = "K";
   localparam logic [7:0] CODE_FG_RED         = "R";
   localparam logic [7:0] CODE_FG_GREEN       = "G";
   localparam logic [7:0] CODE_FG_YELLOW      = "Y";
   localparam logic [7:0] CODE_FG_BLUE        = "B";
   localparam logic [7:0] CODE_FG_MAGENTA     = "M";
   localparam logic [7:0] CODE_FG_CYAN        = "C";
   localparam logic [7:0] CODE_FG_WHITE       = "W";
   localparam logic [7:0] CODE_BG_FIRST       = "0";
   localparam logic [7:0] CODE_BG_LAST        = "7";
   localparam logic [7:0] CODE_SUB            = "Z";
   localparam logic [7:0] CODE_UNKNOWN        = "?";
   localparam logic [7:0] CASE_BIT            = 8'h20;
   localparam logic [7:0] DIGIT_ZERO          = "0";

   localparam int DRAIN_CYCLES = 12;
   localparam int LONG_HOLD    = 80;
   localparam int PHASE_ITEMS  = 60;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PRINT_CAP    = 100;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
   } ansi_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_end;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   ctrl_a_to_ansi_converter u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_end  (rsp_run_end),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // converter state as predicted
   logic          strip_cfg   = 1'b0;
   logic          code_next   = 1'b0;
   logic          stream_done = 1'b0;
   logic [7:0]    conv_run [$];
   ansi_byte_type ansi_expected [$];
   ansi_byte_type rsp_want;

   logic [7:0] pending_reqs [$];
   logic [7:0] known_codes [$];
   logic       gen_code_next = 1'b0;
   int         queued_total = 0;
   int         accepted_total = 0;
   int         bytes_checked = 0;
   int         error_count = 0;
   int         cycle_count = 0;
   int         settings_used = 0;
   int         hold_requests = 0;
   int         holds_served = 0;
   logic       send_gaps_on = 1'b1;
   logic       recv_stalls_on = 1'b1;

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function void push_csi(input string tail);
      conv_run.push_back(ESC_BYTE);
      conv_run.push_back("[");
      for (int i = 0; i < tail.len(); i++)
         conv_run.push_back(tail[i]);
   endfunction

   task automatic convert_request(input logic [7:0] b);
      logic [7:0] upc;
      logic [7:0] digit;
      int         cnt;
      conv_run.delete();
      if (stream_done)
         return;
      if (code_next) begin
         code_next = 1'b0;
         if (b == END_CODE) begin
            stream_done = 1'b1;
            return;
         end
         upc = (b >= "a" && b <= "z") ? (b & ~CASE_BIT) : b;
         if (b > CURSOR_BASE) begin
            cnt = b - CURSOR_BASE;
            conv_run.push_back(ESC_BYTE);
            conv_run.push_back("[");
            if (cnt > 1) begin
               if (cnt >= 100) begin
                  digit = 8'(DIGIT_ZERO + cnt / 100);
                  conv_run.push_back(digit);
               end
               if (cnt >= 10) begin
                  digit = 8'(DIGIT_ZERO + (cnt / 10) % 10);
                  conv_run.push_back(digit);
               end
               digit = 8'(DIGIT_ZERO + cnt % 10);
               conv_run.push_back(digit);
            end
            conv_run.push_back("C");
         end else begin
            case (upc)
               CODE_LITERAL_PREFIX: conv_run.push_back(PREFIX_BYTE);
               CODE_BACKSPACE:      conv_run.push_back(8'h08);
               CODE_ERASE_EOL:      push_csi("K");
               CODE_CR:             conv_run.push_back(8'h0D);
               CODE_LF:             conv_run.push_back(8'h0A);
               CODE_CLEAR_HOME: begin
                  push_csi("2J");
                  push_csi("H");
               end
               CODE_NORMAL, CODE_NORMAL_DASH, CODE_NORMAL_UNDER: push_csi("0m");
               CODE_BOLD:       push_csi("1m");
               CODE_BLINK:      push_csi("5m");
               CODE_FG_BLACK:   push_csi("30m");
               CODE_FG_RED:     push_csi("31m");
               CODE_FG_GREEN:   push_csi("32m");
               CODE_FG_YELLOW:  push_csi("33m");
               CODE_FG_BLUE:    push_csi("34m");
               CODE_FG_MAGENTA: push_csi("35m");
               CODE_FG_CYAN:    push_csi("36m");
               CODE_FG_WHITE:   push_csi("37m");
               // only the lower-case form gets here
               CODE_SUB:        conv_run.push_back(SUB_BYTE);
               default: begin
                  if (upc >= CODE_BG_FIRST && upc <= CODE_BG_LAST) begin
                     push_csi("4");
                     conv_run.push_back(upc);
                     conv_run.push_back("m");
                  end else if (!strip_cfg) begin
                     conv_run.push_back(PREFIX_BYTE);
                     conv_run.push_back(b);
                  end
               end
            endcase
         end
      end else if (b == PREFIX_BYTE) begin
         code_next = 1'b1;
         return;
      end else begin
         conv_run.push_back(b);
      end
      for (int k = 0; k < conv_run.size(); k++)
         ansi_expected.push_back('{out_byte: conv_run[k], run_end: k == conv_run.size() - 1});
   endtask

   task automatic note_mismatch(input string msg);
      if (error_count < PRINT_CAP)
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // driver: hold the request while stalled, idle between requests at random
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            convert_request(req_in_byte);
            accepted_total++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_in_byte <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               gap_left = send_gaps_on ? pick_idle() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each accepted byte, stall at random or for a long hold
   int hold_left = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (ansi_expected.size() == 0) begin
               note_mismatch($sformatf("unexpected byte %h", rsp_out_byte));
            end else begin
               rsp_want = ansi_expected.pop_front();
               if (rsp_out_byte !== rsp_want.out_byte)
                  note_mismatch($sformatf("out_byte %h, expected %h",
                                          rsp_out_byte, rsp_want.out_byte));
               if (rsp_run_end !== rsp_want.run_end)
                  note_mismatch($sformatf("run_end %b, expected %b on byte %h",
                                          rsp_run_end, rsp_want.run_end, rsp_want.out_byte));
               bytes_checked++;
            end
         end
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left == 0 && stall_left == 0 && recv_stalls_on &&
             $urandom_range(0, 99) < 25)
            stall_left = 1 + pick_idle();
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d bytes still expected", ansi_expected.size());
         $display("** ctrl_a_to_ansi_converter: FAILED **");
         $finish;
      end
   end

   // queue one request; never let random content form the end code
   task automatic queue_byte(input logic [7:0] b);
      if (gen_code_next && b == END_CODE)
         b = CODE_SUB | CASE_BIT;
      gen_code_next = gen_code_next ? 1'b0 : (b == PREFIX_BYTE);
      pending_reqs.push_back(b);
      queued_total++;
   endtask

   task automatic queue_code(input logic [7:0] c);
      queue_byte(PREFIX_BYTE);
      queue_byte(c);
   endtask

   function automatic logic [7:0] random_case(input logic [7:0] c);
      if (c >= "A" && c <= "Z" && $urandom_range(0, 1))
         return c | CASE_BIT;
      return c;
   endfunction

   task automatic queue_random(input int n);
      int added;
      int r;
      logic [7:0] b;
      added = 0;
      while (added < n) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            b = 8'($urandom_range(0, 255));
            if (b == PREFIX_BYTE)
               b = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
            queue_byte(b);
            added += 1;
         end else if (r < 75) begin
            queue_code(random_case(known_codes[$urandom_range(0, known_codes.size() - 1)]));
            added += 2;
         end else if (r < 85) begin
            queue_code(8'($urandom_range(CURSOR_BASE + 1, 255)));
            added += 2;
         end else if (r < 93) begin
            queue_code(8'($urandom_range(0, CURSOR_BASE)));
            added += 2;
         end else begin
            // noise: loose prefixes and arbitrary bytes
            repeat ($urandom_range(1, 3)) begin
               queue_byte($urandom_range(0, 1) ? PREFIX_BYTE : 8'($urandom_range(0, 255)));
               added += 1;
            end
         end
      end
   endtask

   task automatic wait_for_drain();
      do @(posedge clock);
      while (accepted_total != queued_total || ansi_expected.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_strip(input logic v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      strip_cfg = v;
      settings_used++;
   endtask

   task automatic set_idling(input logic gaps, input logic stalls);
      @(posedge clock);
      send_gaps_on <= gaps;
      recv_stalls_on <= stalls;
   endtask

   initial begin
      known_codes = '{CODE_LITERAL_PREFIX, CODE_BACKSPACE, CODE_ERASE_EOL, CODE_CR,
                      CODE_LF, CODE_CLEAR_HOME, CODE_NORMAL, CODE_NORMAL_DASH,
                      CODE_NORMAL_UNDER, CODE_BOLD, CODE_BLINK, CODE_FG_BLACK,
                      CODE_FG_RED, CODE_FG_GREEN, CODE_FG_YELLOW, CODE_FG_BLUE,
                      CODE_FG_MAGENTA, CODE_FG_CYAN, CODE_FG_WHITE,
                      CODE_SUB | CASE_BIT};
      for (logic [7:0] c = CODE_BG_FIRST; c <= CODE_BG_LAST; c++)
         known_codes.push_back(c);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, cursor counts, literal prefix, unknown echo
      write_strip(1'b0);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(CURSOR_BASE);
      queue_byte(CURSOR_BASE + 1);
      queue_code(CODE_LITERAL_PREFIX);
      queue_code(CODE_CLEAR_HOME | CASE_BIT);
      queue_code(CURSOR_BASE + 1);
      queue_code(CURSOR_BASE + 9);
      queue_code(CURSOR_BASE + 10);
      queue_code(CURSOR_BASE + 100);
      queue_code(8'hFF);
      queue_code(PREFIX_BYTE);
      queue_code(CODE_SUB | CASE_BIT);
      queue_code(CODE_UNKNOWN);
      wait_for_drain();

      // unknown codes dropped, then every known code once
      write_strip(1'b1);
      queue_code(PREFIX_BYTE);
      queue_code(CODE_UNKNOWN);
      foreach (known_codes[i])
         queue_code(random_case(known_codes[i]));
      wait_for_drain();

      write_strip(1'b0);
      queue_random(PHASE_ITEMS);
      wait_for_drain();

      // long output hold with a busy sender fills the run queue
      write_strip(1'b1);
      set_idling(1'b0, 1'b0);
      hold_requests <= hold_requests + 1;
      queue_random(PHASE_ITEMS);
      wait_for_drain();

      write_strip(1'b0);
      queue_random(PHASE_ITEMS);
      wait_for_drain();

      write_strip(1'b1);
      set_idling(1'b1, 1'b1);
      queue_random(PHASE_ITEMS);
      wait_for_drain();

      // last phase closes the stream; everything after it is dropped
      write_strip(1'b0);
      queue_random(PHASE_ITEMS);
      if (gen_code_next)
         queue_byte(CODE_CR);
      pending_reqs.push_back(PREFIX_BYTE);
      pending_reqs.push_back(END_CODE);
      pending_reqs.push_back(8'h41);
      pending_reqs.push_back(PREFIX_BYTE);
      pending_reqs.push_back(CODE_CLEAR_HOME);
      pending_reqs.push_back(8'hFF);
      queued_total += 6;
      wait_for_drain();

      $display("Sent %0d requests, checked %0d output bytes over %0d strip settings.",
               accepted_total, bytes_checked, settings_used);
      $display("Covered all attribute codes, cursor counts up to 128, %s",
               "unknown codes, end of stream.");
      if (error_count == 0 && ansi_expected.size() == 0) begin
         $display("** ctrl_a_to_ansi_converter: PASSED **");
      end else begin
         $display("%0d mismatches, %0d bytes never seen", error_count, ansi_expected.size());
         $display("** ctrl_a_to_ansi_converter: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/cta2a_pkg.sv
design/cta2a_front.sv
design/cta2a_queue.sv
design/cta2a_back.sv
design/ctrl_a_to_ansi_converter.sv
design/cta2a_checker.sv
tb/sv/ctrl_a_to_ansi_converter_tb.sv
